// ===== design/tlic_pkg.sv =====
// ---------------------------------------------------------------------------
// tlic_pkg - shared types and constants for the two-level interrupt controller
// Command, register kind and group codes, controller/datapath handshake
// structs, and the fixed downstream-to-master routing map.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tlic_pkg;

   localparam int NUM_GROUPS_DEF = 12;

   localparam int DATA_W        = 32;
   localparam int CMD_W         = 2;
   localparam int GROUP_W       = 4;
   localparam int KIND_W        = 2;
   localparam int BIT_W         = 5;
   localparam int REQ_TDATA_W   = 48;
   localparam int RSP_TDATA_W   = 40;
   localparam int MASTER_EN_BIT = 31;

   localparam logic [DATA_W-1:0] LO_HALF = 32'h0000_ffff;
   localparam logic [DATA_W-1:0] HI_HALF = 32'hffff_0000;

   typedef enum logic [CMD_W-1:0] {
      CMD_READ  = 2'd0,
      CMD_WRITE = 2'd1,
      CMD_EVENT = 2'd2,
      CMD_RSVD  = 2'd3
   } command_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_MASK   = 2'd0,
      KIND_ENABLE = 2'd1,
      KIND_IDENT  = 2'd2,
      KIND_STATUS = 2'd3
   } reg_kind_type;

   localparam logic [GROUP_W-1:0] GRP_MASTER = 4'd0;
   localparam logic [GROUP_W-1:0] GRP_GT0    = 4'd1;
   localparam logic [GROUP_W-1:0] GRP_GT1    = 4'd2;
   localparam logic [GROUP_W-1:0] GRP_GT2    = 4'd3;
   localparam logic [GROUP_W-1:0] GRP_GT3    = 4'd4;
   localparam logic [GROUP_W-1:0] GRP_PIPE_A = 4'd5;
   localparam logic [GROUP_W-1:0] GRP_PIPE_B = 4'd6;
   localparam logic [GROUP_W-1:0] GRP_PIPE_C = 4'd7;
   localparam logic [GROUP_W-1:0] GRP_PORT   = 4'd8;
   localparam logic [GROUP_W-1:0] GRP_MISC   = 4'd9;
   localparam logic [GROUP_W-1:0] GRP_PCU    = 4'd10;
   localparam logic [GROUP_W-1:0] GRP_PCH    = 4'd11;

   // decoded class of the transaction being worked on
   typedef enum logic [2:0] {
      OP_BAD       = 3'd0,
      OP_NONE      = 3'd1,
      OP_READ      = 3'd2,
      OP_WR_MASTER = 3'd3,
      OP_WR_MASK   = 3'd4,
      OP_WR_ENABLE = 3'd5,
      OP_WR_IDENT  = 3'd6,
      OP_EVENT     = 3'd7
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE   = 3'd0,
      ST_EXEC   = 3'd1,
      ST_PUSH   = 3'd2,
      ST_WALK   = 3'd3,
      ST_FINISH = 3'd4
   } state_type;

   typedef struct packed {
      logic capture;    // load the request fields
      logic execute;    // perform the primary register operation
      logic push_item;  // route the item's group into the master bits
      logic walk_step;  // pending check: visit one group
      logic walk_push;  // pending check is live (master enable set)
      logic finish;     // load the response register
   } ctrl_cmd_type;

   typedef struct packed {
      op_type op;
      logic   master_en;
      logic   walk_last;
      logic   rsp_free;
   } ctrl_stat_type;

   typedef struct packed {
      logic [DATA_W-1:0] affect;
      logic [DATA_W-1:0] set;
   } route_type;

   // master bits touched by a group and their new values for a given
   // identity AND enable word
   function automatic route_type route_lookup(input logic [GROUP_W-1:0] grp,
                                              input logic [DATA_W-1:0]  val);
      route_type r;
      r.affect = '0;
      r.set    = '0;
      unique case (grp)
         GRP_GT0: begin
            r.affect[0] = 1'b1;  r.set[0] = |(val & LO_HALF);
            r.affect[1] = 1'b1;  r.set[1] = |(val & HI_HALF);
         end
         GRP_GT1: begin
            r.affect[2] = 1'b1;  r.set[2] = |(val & LO_HALF);
            r.affect[3] = 1'b1;  r.set[3] = |(val & HI_HALF);
         end
         GRP_GT2: begin
            r.affect[4] = 1'b1;  r.set[4] = |(val & LO_HALF);
         end
         GRP_GT3: begin
            r.affect[6] = 1'b1;  r.set[6] = |(val & LO_HALF);
         end
         GRP_PIPE_A: begin
            r.affect[16] = 1'b1; r.set[16] = |val;
         end
         GRP_PIPE_B: begin
            r.affect[17] = 1'b1; r.set[17] = |val;
         end
         GRP_PIPE_C: begin
            r.affect[18] = 1'b1; r.set[18] = |val;
         end
         GRP_PORT: begin
            r.affect[20] = 1'b1; r.set[20] = |val;
         end
         GRP_MISC: begin
            r.affect[22] = 1'b1; r.set[22] = |val;
         end
         GRP_PCH: begin
            r.affect[23] = 1'b1; r.set[23] = |val;
         end
         GRP_PCU: begin
            r.affect[30] = 1'b1; r.set[30] = |val;
         end
         default: begin
            r.affect = '0;
         end
      endcase
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== design/two_level_interrupt_controller.sv =====
// ---------------------------------------------------------------------------
// two_level_interrupt_controller - master plus downstream interrupt groups
//
//   channel  dir  tdata bits  contents (low bit first)
//   req      in   48          command[1:0] group[5:2] reg_kind[7:6]
//                             write_data[39:8] bit_index[44:40] zero[47:45]
//   rsp      out  40          read_data[31:0] inject_msi[32] status[33]
//                             zero[39:34]
//
// Sequence: one transaction at a time, from the accept cycle to the
//   response load. Reads, bad groups, the reserved command and status writes
//   go through execute and finish; an identity write adds a route push. A
//   mask write, master write or event walks groups 1..NUM_GROUPS-1 one per
//   cycle when the master enable is set; an enable write adds its route push
//   before the walk.
// Reset: synchronous; all group registers and the master register clear.
// Stalls: the next transaction is taken while a response still waits in the
//   output register; a finished transaction holds until that register frees.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module two_level_interrupt_controller #(
   parameter int NUM_GROUPS = tlic_pkg::NUM_GROUPS_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // request transactions
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   // command, group, reg_kind, write_data, bit_index
   input  wire logic [tlic_pkg::REQ_TDATA_W-1:0]    req_tdata,
   // response transactions
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   // read_data, inject_msi, status
   output logic [tlic_pkg::RSP_TDATA_W-1:0]         rsp_tdata
);

   localparam int DW     = tlic_pkg::DATA_W;
   localparam int RSP_PAD = tlic_pkg::RSP_TDATA_W - DW - 2;

   tlic_pkg::ctrl_cmd_type  cmd;
   tlic_pkg::ctrl_stat_type stat;

   // request field unpack
   logic [tlic_pkg::CMD_W-1:0]   req_command;
   logic [tlic_pkg::GROUP_W-1:0] req_group;
   logic [tlic_pkg::KIND_W-1:0]  req_reg_kind;
   logic [DW-1:0]                req_write_data;
   logic [tlic_pkg::BIT_W-1:0]   req_bit_index;

   assign req_command    = req_tdata[1:0];
   assign req_group      = req_tdata[5:2];
   assign req_reg_kind   = req_tdata[7:6];
   assign req_write_data = req_tdata[39:8];
   assign req_bit_index  = req_tdata[44:40];

   logic [DW-1:0] rsp_read_data;
   logic          rsp_inject_msi;
   logic          rsp_status;

   // sequencer: one transaction through execute / push / walk / finish
   tlic_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   // register file, routing map, walk counter and response register
   tlic_datapath #(
      .NUM_GROUPS (NUM_GROUPS)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .req_command    (req_command),
      .req_group      (req_group),
      .req_reg_kind   (req_reg_kind),
      .req_write_data (req_write_data),
      .req_bit_index  (req_bit_index),
      .cmd            (cmd),
      .stat           (stat),
      .rsp_tready     (rsp_tready),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_read_data  (rsp_read_data),
      .rsp_inject_msi (rsp_inject_msi),
      .rsp_status     (rsp_status)
   );

   assign rsp_tdata = {{RSP_PAD{1'b0}}, rsp_status, rsp_inject_msi, rsp_read_data};

endmodule

`default_nettype wire

// ===== design/tlic_ctrl.sv =====
// ---------------------------------------------------------------------------
// tlic_ctrl - sequencing state machine
// Steps each transaction through execute, optional route push, the
// pending-check walk and the response load.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tlic_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   input  wire tlic_pkg::ctrl_stat_type stat,
   output tlic_pkg::ctrl_cmd_type      cmd
);

   tlic_pkg::state_type state_ff;
   tlic_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tlic_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         tlic_pkg::ST_IDLE: begin
            if (req_tvalid) state_in = tlic_pkg::ST_EXEC;
         end
         tlic_pkg::ST_EXEC: begin
            unique case (stat.op)
               tlic_pkg::OP_WR_MASTER,
               tlic_pkg::OP_WR_MASK,
               tlic_pkg::OP_EVENT:     state_in = tlic_pkg::ST_WALK;
               tlic_pkg::OP_WR_ENABLE,
               tlic_pkg::OP_WR_IDENT:  state_in = tlic_pkg::ST_PUSH;
               default:                state_in = tlic_pkg::ST_FINISH;
            endcase
         end
         tlic_pkg::ST_PUSH: begin
            state_in = (stat.op == tlic_pkg::OP_WR_ENABLE) ? tlic_pkg::ST_WALK
                                                             : tlic_pkg::ST_FINISH;
         end
         tlic_pkg::ST_WALK: begin
            if (!stat.master_en || stat.walk_last) state_in = tlic_pkg::ST_FINISH;
         end
         tlic_pkg::ST_FINISH: begin
            if (stat.rsp_free) state_in = tlic_pkg::ST_IDLE;
         end
         default: begin
            state_in = tlic_pkg::ST_IDLE;
         end
      endcase
   end

   // outputs
   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         tlic_pkg::ST_IDLE: begin
            req_tready  = 1'b1;
            cmd.capture = req_tvalid;
         end
         tlic_pkg::ST_EXEC: begin
            cmd.execute = 1'b1;
         end
         tlic_pkg::ST_PUSH: begin
            cmd.push_item = 1'b1;
         end
         tlic_pkg::ST_WALK: begin
            cmd.walk_step = 1'b1;
            cmd.walk_push = stat.master_en;
         end
         tlic_pkg::ST_FINISH: begin
            cmd.finish = stat.rsp_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

`default_nettype wire

// ===== design/tlic_datapath.sv =====
// ---------------------------------------------------------------------------
// tlic_datapath - register file, routing logic and response register
// Holds mask/enable/identity per group, the master register, the captured
// transaction, the pending-check walk counter and the output stage.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tlic_datapath #(
   parameter int NUM_GROUPS = tlic_pkg::NUM_GROUPS_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic [tlic_pkg::CMD_W-1:0]          req_command,
   input  wire logic [tlic_pkg::GROUP_W-1:0]        req_group,
   input  wire logic [tlic_pkg::KIND_W-1:0]         req_reg_kind,
   input  wire logic [tlic_pkg::DATA_W-1:0]         req_write_data,
   input  wire logic [tlic_pkg::BIT_W-1:0]          req_bit_index,
   input  wire tlic_pkg::ctrl_cmd_type              cmd,
   output tlic_pkg::ctrl_stat_type                  stat,
   input  wire logic                                rsp_tready,
   output logic                                     rsp_tvalid,
   output logic [tlic_pkg::DATA_W-1:0]              rsp_read_data,
   output logic                                     rsp_inject_msi,
   output logic                                     rsp_status
);

   localparam int IDX_W = $clog2(NUM_GROUPS);
   localparam int GW    = tlic_pkg::GROUP_W;
   localparam int DW    = tlic_pkg::DATA_W;
   localparam int MEN   = tlic_pkg::MASTER_EN_BIT;

   // register file
   logic [DW-1:0] mask_ff   [NUM_GROUPS];
   logic [DW-1:0] mask_in   [NUM_GROUPS];
   logic [DW-1:0] enable_ff [NUM_GROUPS];
   logic [DW-1:0] enable_in [NUM_GROUPS];
   logic [DW-1:0] ident_ff  [NUM_GROUPS];
   logic [DW-1:0] ident_in  [NUM_GROUPS];
   logic [DW-1:0] master_ff;
   logic [DW-1:0] master_in;

   // captured transaction
   tlic_pkg::command_type  cmd_ff;
   tlic_pkg::reg_kind_type kind_ff;
   logic [GW-1:0]             grp_ff;
   logic [DW-1:0]             data_ff;
   logic [tlic_pkg::BIT_W-1:0] bit_ff;

   // walk and result
   logic [IDX_W-1:0] walk_ff;
   logic [IDX_W-1:0] walk_in;
   logic             check_ff;
   logic             check_in;
   logic [DW-1:0]    rd_ff;
   logic [DW-1:0]    rd_in;
   logic             st_ff;
   logic             st_in;
   logic             rsp_valid_ff;
   logic             rsp_valid_in;
   logic [DW-1:0]    rsp_rd_ff;
   logic             rsp_msi_ff;
   logic             rsp_st_ff;

   logic               grp_ok;
   logic [IDX_W-1:0]   grp_idx;
   logic [IDX_W-1:0]   sel_idx;
   logic [DW-1:0]      sel_val;
   logic [GW-1:0]      route_grp;
   logic               do_route;
   logic               msi;
   tlic_pkg::route_type route;
   tlic_pkg::op_type    op;

   assign grp_ok  = ({1'b0, grp_ff} < (GW+1)'(NUM_GROUPS));
   assign grp_idx = grp_ff[IDX_W-1:0];

   // transaction decode
   always_comb begin
      op = tlic_pkg::OP_NONE;
      if (!grp_ok) begin
         op = tlic_pkg::OP_BAD;
      end else begin
         unique case (cmd_ff)
            tlic_pkg::CMD_READ:  op = tlic_pkg::OP_READ;
            tlic_pkg::CMD_WRITE: begin
               if (grp_ff == tlic_pkg::GRP_MASTER) begin
                  op = tlic_pkg::OP_WR_MASTER;
               end else begin
                  unique case (kind_ff)
                     tlic_pkg::KIND_MASK:   op = tlic_pkg::OP_WR_MASK;
                     tlic_pkg::KIND_ENABLE: op = tlic_pkg::OP_WR_ENABLE;
                     tlic_pkg::KIND_IDENT:  op = tlic_pkg::OP_WR_IDENT;
                     default:               op = tlic_pkg::OP_NONE;
                  endcase
               end
            end
            tlic_pkg::CMD_EVENT: op = tlic_pkg::OP_EVENT;
            default:             op = tlic_pkg::OP_NONE;
         endcase
      end
   end

   // one read port into identity/enable: item group or walk group
   assign sel_idx   = cmd.walk_step ? walk_ff : grp_idx;
   assign sel_val   = ident_ff[sel_idx] & enable_ff[sel_idx];
   assign route_grp = cmd.walk_step ? GW'(walk_ff) : grp_ff;
   assign route     = tlic_pkg::route_lookup(route_grp, sel_val);
   assign do_route  = cmd.push_item | (cmd.walk_push & (|sel_val));

   always_comb begin
      mask_in   = mask_ff;
      enable_in = enable_ff;
      ident_in  = ident_ff;
      master_in = master_ff;
      rd_in     = rd_ff;
      st_in     = st_ff;
      if (cmd.execute) begin
         rd_in = '0;
         st_in = (op == tlic_pkg::OP_BAD);
         unique case (op)
            tlic_pkg::OP_READ: begin
               if (grp_ff == tlic_pkg::GRP_MASTER) begin
                  rd_in = master_ff;
               end else begin
                  unique case (kind_ff)
                     tlic_pkg::KIND_MASK:   rd_in = mask_ff[grp_idx];
                     tlic_pkg::KIND_ENABLE: rd_in = enable_ff[grp_idx];
                     tlic_pkg::KIND_IDENT:  rd_in = ident_ff[grp_idx];
                     default:               rd_in = '0;
                  endcase
               end
            end
            tlic_pkg::OP_WR_MASTER: master_in[MEN] = data_ff[MEN];
            tlic_pkg::OP_WR_MASK:   mask_in[grp_idx] = data_ff;
            tlic_pkg::OP_WR_ENABLE: enable_in[grp_idx] = data_ff;
            tlic_pkg::OP_WR_IDENT:  ident_in[grp_idx] = ident_ff[grp_idx] & ~data_ff;
            tlic_pkg::OP_EVENT: begin
               // master events and masked bits set nothing
               if (grp_ff != tlic_pkg::GRP_MASTER && !mask_ff[grp_idx][bit_ff]) begin
                  ident_in[grp_idx][bit_ff] = 1'b1;
               end
            end
            default: begin
               rd_in = '0;
            end
         endcase
      end
      if (do_route) begin
         master_in = (master_ff & ~route.affect) | route.set;
      end
   end

   // walk covers groups 1 .. NUM_GROUPS-1
   always_comb begin
      walk_in  = walk_ff;
      check_in = check_ff;
      if (cmd.capture) begin
         walk_in  = IDX_W'(1);
         check_in = 1'b0;
      end else if (cmd.walk_step) begin
         walk_in  = walk_ff + IDX_W'(1);
         check_in = 1'b1;
      end
   end

   assign msi = check_ff & master_ff[MEN] & (|master_ff[MEN-1:0]);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_GROUPS; i++) begin
            mask_ff[i]   <= '0;
            enable_ff[i] <= '0;
            ident_ff[i]  <= '0;
         end
         master_ff    <= '0;
         rsp_valid_ff <= 1'b0;
         check_ff     <= 1'b0;
         walk_ff      <= IDX_W'(1);
      end else begin
         mask_ff      <= mask_in;
         enable_ff    <= enable_in;
         ident_ff     <= ident_in;
         master_ff    <= master_in;
         rsp_valid_ff <= rsp_valid_in;
         check_ff     <= check_in;
         walk_ff      <= walk_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         cmd_ff  <= tlic_pkg::command_type'(req_command);
         grp_ff  <= req_group;
         kind_ff <= tlic_pkg::reg_kind_type'(req_reg_kind);
         data_ff <= req_write_data;
         bit_ff  <= req_bit_index;
      end
      rd_ff <= rd_in;
      st_ff <= st_in;
      if (cmd.finish) begin
         rsp_rd_ff  <= rd_ff;
         rsp_msi_ff <= msi;
         rsp_st_ff  <= st_ff;
      end
   end

   assign stat.op        = op;
   assign stat.master_en = master_ff[MEN];
   assign stat.walk_last = (walk_ff == IDX_W'(NUM_GROUPS - 1));
   assign stat.rsp_free  = ~rsp_valid_ff | rsp_tready;

   assign rsp_tvalid     = rsp_valid_ff;
   assign rsp_read_data  = rsp_rd_ff;
   assign rsp_inject_msi = rsp_msi_ff;
   assign rsp_status     = rsp_st_ff;

endmodule

`default_nettype wire

// ===== bench/interrupt_response_checker.sv =====
// ---------------------------------------------------------------------------
// interrupt_response_checker - response predictor for the interrupt controller
// Follows every request transaction into its own copy of the mask, enable,
// identity and master registers, queues the response each one must produce,
// and compares the responses the block sends against that queue, in order.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module interrupt_response_checker #(
   parameter int NUM_GROUPS = tlic_pkg::NUM_GROUPS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   input  logic                             req_tready,
   input  logic [tlic_pkg::REQ_TDATA_W-1:0] req_tdata,
   input  logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   input  logic [tlic_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   output int                               error_count,
   output int                               responses_owed
);
   import tlic_pkg::*;

   localparam int ROUTE_LEN     = 13;

   typedef struct packed {
      logic [DATA_W-1:0] read_data;
      logic              inject_msi;
      logic              status;
   } response_type;

   logic [DATA_W-1:0] mask_q   [NUM_GROUPS];
   logic [DATA_W-1:0] enable_q [NUM_GROUPS];
   logic [DATA_W-1:0] ident_q  [NUM_GROUPS];
   logic [DATA_W-1:0] master_q;
   response_type      owed_q [$];

   // downstream group, master bit and the group bits that drive it
   function automatic void route_entry(input int idx, output logic [GROUP_W-1:0] grp,
                                       output int up_bit, output logic [DATA_W-1:0] sel);
      case (idx)
         0:  begin grp = GRP_GT0;    up_bit = 0;  sel = LO_HALF; end
         1:  begin grp = GRP_GT0;    up_bit = 1;  sel = HI_HALF; end
         2:  begin grp = GRP_GT1;    up_bit = 2;  sel = LO_HALF; end
         3:  begin grp = GRP_GT1;    up_bit = 3;  sel = HI_HALF; end
         4:  begin grp = GRP_GT2;    up_bit = 4;  sel = LO_HALF; end
         5:  begin grp = GRP_GT3;    up_bit = 6;  sel = LO_HALF; end
         6:  begin grp = GRP_PIPE_A; up_bit = 16; sel = '1;      end
         7:  begin grp = GRP_PIPE_B; up_bit = 17; sel = '1;      end
         8:  begin grp = GRP_PIPE_C; up_bit = 18; sel = '1;      end
         9:  begin grp = GRP_PORT;   up_bit = 20; sel = '1;      end
         10: begin grp = GRP_MISC;   up_bit = 22; sel = '1;      end
         11: begin grp = GRP_PCH;    up_bit = 23; sel = '1;      end
         default: begin grp = GRP_PCU; up_bit = 30; sel = '1;   end
      endcase
   endfunction

   // set or clear the master bits owned by group g from identity AND enable
   function automatic void refresh_master(input int g);
      logic [DATA_W-1:0]  live;
      logic [DATA_W-1:0]  on_bits;
      logic [DATA_W-1:0]  clr_bits;
      logic [DATA_W-1:0]  sel;
      logic [GROUP_W-1:0] grp;
      int                 up_bit;
      on_bits  = '0;
      clr_bits = '0;
      if (g == int'(GRP_MASTER) || g >= NUM_GROUPS) return;
      live = ident_q[g] & enable_q[g];
      for (int i = 0; i < ROUTE_LEN; i++) begin
         route_entry(i, grp, up_bit, sel);
         if (int'(grp) != g) continue;
         if ((live & sel) != '0) on_bits[up_bit]  = 1'b1;
         else                    clr_bits[up_bit] = 1'b1;
      end
      master_q = (master_q & ~clr_bits) | on_bits;
   endfunction

   // only live with the master enable; touches groups with something live only
   function automatic logic run_pending_check();
      if (!master_q[MASTER_EN_BIT]) return 1'b0;
      for (int g = 1; g < NUM_GROUPS; g++)
         if ((ident_q[g] & enable_q[g]) != '0) refresh_master(g);
      return |master_q[MASTER_EN_BIT-1:0];
   endfunction

   function automatic response_type predict_response(input logic [REQ_TDATA_W-1:0] word);
      command_type       cmd;
      reg_kind_type      kind;
      logic [DATA_W-1:0] data;
      int                g;
      int                bidx;
      response_type      r;
      cmd  = command_type'(word[1:0]);
      g    = int'(word[5:2]);
      kind = reg_kind_type'(word[7:6]);
      data = word[39:8];
      bidx = int'(word[44:40]);
      r    = '0;
      if (g >= NUM_GROUPS) begin
         r.status = 1'b1;
      end else begin
         case (cmd)
            CMD_READ: begin
               if (g == int'(GRP_MASTER)) r.read_data = master_q;
               else begin
                  case (kind)
                     KIND_MASK:   r.read_data = mask_q[g];
                     KIND_ENABLE: r.read_data = enable_q[g];
                     KIND_IDENT:  r.read_data = ident_q[g];
                     default:     r.read_data = '0;
                  endcase
               end
            end
            CMD_WRITE: begin
               if (g == int'(GRP_MASTER)) begin
                  master_q[MASTER_EN_BIT] = data[MASTER_EN_BIT];
                  r.inject_msi = run_pending_check();
               end else begin
                  case (kind)
                     KIND_MASK: begin
                        mask_q[g] = data;
                        r.inject_msi = run_pending_check();
                     end
                     KIND_ENABLE: begin
                        enable_q[g] = data;
                        refresh_master(g);
                        r.inject_msi = run_pending_check();
                     end
                     KIND_IDENT: begin
                        ident_q[g] &= ~data;
                        refresh_master(g);
                     end
                     default: ;
                  endcase
               end
            end
            CMD_EVENT: begin
               if (g != int'(GRP_MASTER) && !mask_q[g][bidx]) ident_q[g][bidx] = 1'b1;
               r.inject_msi = run_pending_check();
            end
            default: ;
         endcase
      end
      return r;
   endfunction

   function automatic void report_mismatch(input string field, input logic [DATA_W-1:0] want,
                                           input logic [DATA_W-1:0] got);
      error_count++;
      $display("%0t: %s mismatch, expected 0x%08h, actual 0x%08h", $time, field, want, got);
   endfunction

   initial error_count = 0;

   // responses are handled before requests: a response in the same cycle
   // always belongs to an older transaction
   always @(posedge clock) begin
      response_type seen;
      response_type want;
      if (reset) begin
         for (int g = 0; g < NUM_GROUPS; g++) begin
            mask_q[g]   = '0;
            enable_q[g] = '0;
            ident_q[g]  = '0;
         end
         master_q = '0;
         owed_q.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            seen.read_data  = rsp_tdata[31:0];
            seen.inject_msi = rsp_tdata[32];
            seen.status     = rsp_tdata[33];
            if (owed_q.size() == 0) begin
               error_count++;
               $display("%0t: unexpected response, expected none, actual %h", $time, seen);
            end else begin
               want = owed_q.pop_front();
               if (seen.read_data != want.read_data)
                  report_mismatch("read_data", want.read_data, seen.read_data);
               if (seen.inject_msi != want.inject_msi)
                  report_mismatch("inject_msi", 32'(want.inject_msi), 32'(seen.inject_msi));
               if (seen.status != want.status)
                  report_mismatch("status", 32'(want.status), 32'(seen.status));
            end
         end
         if (req_tvalid && req_tready) owed_q.push_back(predict_response(req_tdata));
      end
      responses_owed <= owed_q.size();
   end

endmodule

// ===== bench/two_level_interrupt_controller_tb.sv =====
// ---------------------------------------------------------------------------
// two_level_interrupt_controller_tb - testbench top for the interrupt controller
// Drives a short directed sequence and then random register accesses and
// events through three idle patterns; a separate checker predicts and
// compares every response. Verdict comes from the checker's error count.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module two_level_interrupt_controller_tb;
   import tlic_pkg::*;

   // no-handshake cycles before the run is declared hung; well above the longest
   // transaction, leaving headroom for long random stalls
   localparam int STALL_LIMIT      = 2000;
   localparam int RANDOM_PER_PHASE = 660;
   localparam int DRAIN_CYCLES     = 32;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;

   int req_idle_pct = 35;   // chance per transaction of a sender gap cycle
   int rsp_idle_pct = 55;   // chance per cycle of the receiver stalling
   int quiet_cycles = 0;
   int fail_count;
   int responses_owed;

   // 8 ns clock
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   two_level_interrupt_controller #(
      .NUM_GROUPS (NUM_GROUPS_DEF)
   ) uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   interrupt_response_checker #(
      .NUM_GROUPS (NUM_GROUPS_DEF)
   ) response_check (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .error_count    (fail_count),
      .responses_owed (responses_owed)
   );

   // receiver back-pressure, redrawn every falling edge
   always @(negedge clock) rsp_tready <= ($urandom_range(0, 99) >= rsp_idle_pct);

   // hang detection: any accepted transaction on either side restarts the count
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles == STALL_LIMIT) begin
            $display("two_level_interrupt_controller_tb: FAIL");
            $finish;
         end
      end
   end

   // tdata layout: command, group, reg_kind, write_data, bit_index, zero pad
   function automatic logic [REQ_TDATA_W-1:0] make_request(
      input command_type cmd, input logic [GROUP_W-1:0] grp, input reg_kind_type kind,
      input logic [DATA_W-1:0] data, input logic [BIT_W-1:0] bidx);
      return {3'b000, bidx, data, kind, grp, cmd};
   endfunction

   // Mostly in-range groups with writes, events and reads; the master enable
   // is switched on often so pending checks actually walk the groups.
   function automatic logic [REQ_TDATA_W-1:0] random_request();
      int                 pick;
      command_type        cmd;
      logic [GROUP_W-1:0] grp;
      reg_kind_type       kind;
      logic [DATA_W-1:0]  data;
      pick = $urandom_range(0, 99);
      grp  = GROUP_W'($urandom_range(1, 11));
      if ($urandom_range(0, 19) == 0)     grp = GROUP_W'($urandom_range(12, 15));
      else if ($urandom_range(0, 9) == 0) grp = GRP_MASTER;
      kind = reg_kind_type'(KIND_W'($urandom_range(0, 3)));
      case ($urandom_range(0, 3))
         0:       data = $urandom();
         1:       data = 32'h1 << $urandom_range(0, 31);
         2:       data = '0;
         default: data = '1;
      endcase
      if (pick < 40)      cmd = CMD_EVENT;
      else if (pick < 75) cmd = CMD_WRITE;
      else if (pick < 96) cmd = CMD_READ;
      else                cmd = CMD_RSVD;
      if (cmd == CMD_WRITE && grp == GRP_MASTER && $urandom_range(0, 3) != 0)
         data[MASTER_EN_BIT] = 1'b1;
      // sparse masks so most events get through
      if (cmd == CMD_WRITE && kind == KIND_MASK && $urandom_range(0, 1) == 1)
         data &= $urandom() & $urandom();
      return make_request(cmd, grp, kind, data, BIT_W'($urandom_range(0, 31)));
   endfunction

   // called at a falling edge; returns at the falling edge after acceptance.
   // valid is left high so back-to-back transactions need no re-raise.
   task automatic send_request(input logic [REQ_TDATA_W-1:0] word);
      while ($urandom_range(0, 99) < req_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tdata  <= word;
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   initial begin
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // --- directed ---
      // reset value of master
      send_request(make_request(CMD_READ,  GRP_MASTER, KIND_MASK,   '0,           5'd0));
      // identity bit set while master enable is off: no message yet
      send_request(make_request(CMD_WRITE, GRP_GT0,    KIND_ENABLE, '1,           5'd0));
      send_request(make_request(CMD_EVENT, GRP_GT0,    KIND_MASK,   '0,           5'd0));
      // master enable on: pending check picks up GT0 low half
      send_request(make_request(CMD_WRITE, GRP_MASTER, KIND_MASK,   32'h8000_0000, 5'd0));
      send_request(make_request(CMD_READ,  GRP_MASTER, KIND_IDENT,  '0,           5'd0));
      send_request(make_request(CMD_READ,  GRP_GT0,    KIND_IDENT,  '0,           5'd0));
      // top bit lands in the GT0 high-half master bit
      send_request(make_request(CMD_EVENT, GRP_GT0,    KIND_MASK,   '0,           5'd31));
      // identity clear pushes both GT0 master bits back to zero, no check
      send_request(make_request(CMD_WRITE, GRP_GT0,    KIND_IDENT,  '1,           5'd0));
      // fully masked group drops its event
      send_request(make_request(CMD_WRITE, GRP_GT1,    KIND_MASK,   '1,           5'd0));
      send_request(make_request(CMD_EVENT, GRP_GT1,    KIND_MASK,   '0,           5'd5));
      send_request(make_request(CMD_READ,  GRP_GT1,    KIND_IDENT,  '0,           5'd0));
      send_request(make_request(CMD_READ,  GRP_GT1,    KIND_MASK,   '0,           5'd0));
      // status register: writes ignored, reads zero
      send_request(make_request(CMD_WRITE, GRP_GT2,    KIND_STATUS, 32'h0000_ffff, 5'd0));
      send_request(make_request(CMD_READ,  GRP_GT2,    KIND_STATUS, '0,           5'd0));
      // reserved command, in range and out of range
      send_request(make_request(CMD_RSVD,  GRP_PIPE_A, KIND_ENABLE, '1,           5'd31));
      send_request(make_request(CMD_RSVD,  4'd14,      KIND_MASK,   '0,           5'd0));
      // groups that do not exist
      send_request(make_request(CMD_READ,  4'd12,      KIND_MASK,   '0,           5'd0));
      send_request(make_request(CMD_WRITE, 4'd15,      KIND_IDENT,  '1,           5'd31));
      send_request(make_request(CMD_EVENT, 4'd13,      KIND_MASK,   '0,           5'd7));
      // event on the master group sets nothing but still runs the check
      send_request(make_request(CMD_EVENT, GRP_MASTER, KIND_MASK,   '0,           5'd7));
      // PCU and PCH routes
      send_request(make_request(CMD_WRITE, GRP_PCU,    KIND_ENABLE, 32'h0000_0001, 5'd0));
      send_request(make_request(CMD_EVENT, GRP_PCU,    KIND_MASK,   '0,           5'd0));
      send_request(make_request(CMD_WRITE, GRP_PCH,    KIND_ENABLE, '1,           5'd0));
      send_request(make_request(CMD_EVENT, GRP_PCH,    KIND_MASK,   '0,           5'd31));
      // master write leaves all but the enable bit alone
      send_request(make_request(CMD_WRITE, GRP_MASTER, KIND_MASK,   32'h7fff_ffff, 5'd0));
      send_request(make_request(CMD_READ,  GRP_MASTER, KIND_MASK,   '0,           5'd0));

      // --- random, three idle patterns ---
      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0:       begin req_idle_pct = 35; rsp_idle_pct = 55; end
            1:       begin req_idle_pct = 55; rsp_idle_pct = 35; end
            default: begin req_idle_pct = 0;  rsp_idle_pct = 0;  end
         endcase
         repeat (RANDOM_PER_PHASE) send_request(random_request());
      end
      req_tvalid <= 1'b0;

      // drain, then keep watching for any stray response
      while (responses_owed != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fail_count == 0) begin
         $display("two_level_interrupt_controller_tb: PASS");
      end else begin
         $display("two_level_interrupt_controller_tb: FAIL");
      end
      $finish;
   end

endmodule

// ===== files.f =====
design/tlic_pkg.sv
design/tlic_ctrl.sv
design/tlic_datapath.sv
design/two_level_interrupt_controller.sv
bench/interrupt_response_checker.sv
bench/two_level_interrupt_controller_tb.sv
